>>> design/bcpe_pkg.sv
`default_nettype none

package bcpe_pkg;

  // defaults for the top-level parameters
  localparam int MAX_POINTS_DEF  = 4;
  localparam int COORD_BITS_DEF  = 10;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W   = 3;
  localparam int CNT_W       = 3;
  localparam int DEG_W       = 2;   // degree is at most 3
  localparam int QUEUE_DEPTH = 4;   // power of two

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT0 = 3'd0,
    REG_POINT1 = 3'd1,
    REG_POINT2 = 3'd2,
    REG_POINT3 = 3'd3,
    REG_COUNT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             zero;  // no control points: result is the origin
    logic [DEG_W-1:0] deg;
  } item_cls_t;

  // binomial coefficient C(n,i), zero for i > n
  function automatic logic [1:0] binom(input logic [DEG_W-1:0] n,
                                       input logic [DEG_W-1:0] i);
    logic [1:0] c;
    if (i > n) begin
      c = 2'd0;
    end else if (i == 2'd0 || i == n) begin
      c = 2'd1;
    end else if (n == 2'd3) begin
      c = 2'd3;
    end else begin
      c = 2'd2;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/bezier_curve_point_evaluator.sv
// Bezier curve point evaluator, Bernstein form, up to MAX_POINTS control points.
//
// Configuration: cfg_valid/cfg_index/cfg_data writes one register per request,
// cfg_ready is always high. Index 0..3 are control points (x in the low
// COORD_BITS, y above), index 4 is the point count; a count above MAX_POINTS
// is stored as MAX_POINTS. Write only while no request is in flight.
// Input: in_tdata carries t in unsigned Q1.T_FRAC_BITS; values above one
// clamp to one. Output: out_tdata carries x and y with 8 fraction bits.
//
// The pipe holds a queue stage, a weight-load stage, one stage per Bernstein
// multiply step (MAX_POINTS-1), a coordinate multiply stage and the sum/round
// output stage. Throughput is one point per cycle while the output is not held.
// When out_tvalid is high and out_tready low the back pipe holds; the 4-entry
// queue keeps taking requests until it fills, then in_tready drops.
// Reset (rst_n low, synchronous) empties the pipe and queue and clears the
// configuration registers to zero; a count of zero yields the point (0,0).
`default_nettype none

module bezier_curve_point_evaluator #(
  parameter int MAX_POINTS  = bcpe_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS  = bcpe_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = bcpe_pkg::T_FRAC_BITS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  // [T_FRAC_BITS:0] t_value, zero padded to bytes
  input  wire logic [((T_FRAC_BITS + 8) / 8) * 8 - 1:0]  in_tdata,
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  // curve_x, then curve_y, zero padded to bytes
  output logic [((2 * (COORD_BITS + 8) + 7) / 8) * 8 - 1:0] out_tdata,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [bcpe_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [2*COORD_BITS-1:0]                   cfg_data
);
  import bcpe_pkg::*;

  localparam int TW    = T_FRAC_BITS + 1;
  localparam int RW    = COORD_BITS + 8;
  localparam int OUT_W = ((2 * RW + 7) / 8) * 8;
  localparam int CLSW  = $bits(item_cls_t);
  localparam int QW    = CLSW + 2 * TW;
  localparam int PIW   = (MAX_POINTS > 2) ? 2 : 1;

  logic [MAX_POINTS-1:0][2*COORD_BITS-1:0] pt_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_wr;

  logic              q_push, q_full, q_pop, q_empty;
  logic [TW-1:0]     f_t, f_u;
  item_cls_t         f_cls;
  logic [QW-1:0]     q_wdata, q_rdata;
  item_cls_t         b_cls;
  logic [RW-1:0]     res_x, res_y;

  assign cfg_ready = 1'b1;
  assign cnt_wr = (cfg_data[CNT_W-1:0] > CNT_W'(MAX_POINTS)) ?
                  CNT_W'(MAX_POINTS) : cfg_data[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r  <= '0;
      cnt_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index)) inside
        REG_POINT0, REG_POINT1, REG_POINT2, REG_POINT3: begin
          if (cfg_index < CFG_IDX_W'(MAX_POINTS)) begin
            pt_r[cfg_index[PIW-1:0]] <= cfg_data;
          end
        end
        REG_COUNT: begin
          cnt_r <= cnt_wr;
        end
        default: begin
        end
      endcase
    end
  end

  bcpe_front #(
    .MAX_POINTS  (MAX_POINTS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_t        (in_tdata[TW-1:0]),
    .point_count (cnt_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_t         (f_t),
    .q_u         (f_u),
    .q_cls       (f_cls)
  );

  assign q_wdata = {f_cls, f_u, f_t};

  bcpe_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign b_cls = q_rdata[QW-1 -: CLSW];

  bcpe_back #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_t        (q_rdata[TW-1:0]),
    .q_u        (q_rdata[2*TW-1:TW]),
    .q_cls      (b_cls),
    .points     (pt_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_x      (res_x),
    .out_y      (res_y)
  );

  assign out_tdata = OUT_W'({res_y, res_x});

endmodule

`default_nettype wire

>>> design/bcpe_front.sv
`default_nettype none

module bcpe_front #(
  parameter int MAX_POINTS  = bcpe_pkg::MAX_POINTS_DEF,
  parameter int T_FRAC_BITS = bcpe_pkg::T_FRAC_BITS_DEF
) (
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [T_FRAC_BITS:0]         in_t,
  input  wire logic [bcpe_pkg::CNT_W-1:0]   point_count,
  input  wire logic                         q_full,
  output logic                              q_push,
  output logic [T_FRAC_BITS:0]              q_t,
  output logic [T_FRAC_BITS:0]              q_u,
  output bcpe_pkg::item_cls_t               q_cls
);
  import bcpe_pkg::*;

  localparam int TW = T_FRAC_BITS + 1;
  localparam logic [TW-1:0] ONE = TW'(1) << T_FRAC_BITS;

  logic [CNT_W-1:0] deg_full;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // t above one clamps to one
  assign q_t = (in_t > ONE) ? ONE : in_t;
  assign q_u = ONE - q_t;

  assign deg_full   = point_count - CNT_W'(1);
  assign q_cls.zero = (point_count == '0);
  assign q_cls.deg  = deg_full[DEG_W-1:0];

endmodule

`default_nettype wire

>>> design/bcpe_fifo.sv
`default_nettype none

module bcpe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bcpe_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  import bcpe_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count lost a request");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> design/bcpe_back.sv
`default_nettype none

module bcpe_back #(
  parameter int MAX_POINTS  = bcpe_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS  = bcpe_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = bcpe_pkg::T_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_empty,
  output logic                                  q_pop,
  input  wire logic [T_FRAC_BITS:0]             q_t,
  input  wire logic [T_FRAC_BITS:0]             q_u,
  input  wire bcpe_pkg::item_cls_t              q_cls,
  input  wire logic [MAX_POINTS-1:0][2*COORD_BITS-1:0] points,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [COORD_BITS+7:0]                 out_x,
  output logic [COORD_BITS+7:0]                 out_y
);
  import bcpe_pkg::*;

  localparam int TW   = T_FRAC_BITS + 1;
  localparam int WB   = T_FRAC_BITS + 2;       // weight, up to 3.0
  localparam int MW   = WB + TW;
  localparam int NSTG = MAX_POINTS - 1;        // multiply steps
  localparam int PW   = WB + COORD_BITS;
  localparam int ACCW = PW + 2;
  localparam int FINW = ACCW + 8;
  localparam int RW   = COORD_BITS + 8;
  localparam logic [MW-1:0]   HALF_M   = MW'(1) << (T_FRAC_BITS - 1);
  localparam logic [FINW-1:0] HALF_F   = FINW'(1) << (T_FRAC_BITS - 1);
  localparam logic [FINW-1:0] OUT_MAX  = FINW'((1 << RW) - 1);

  logic adv;

  logic            vld_r  [NSTG+1];
  item_cls_t       cls_r  [NSTG+1];
  logic [TW-1:0]   t_r    [NSTG];
  logic [TW-1:0]   u_r    [NSTG];
  logic [WB-1:0]   b_r    [NSTG+1][MAX_POINTS];
  logic [WB-1:0]   b_nxt  [NSTG][MAX_POINTS];
  logic [WB-1:0]   b_init [MAX_POINTS];

  logic            prod_vld_r;
  logic [PW-1:0]   px_r [MAX_POINTS];
  logic [PW-1:0]   py_r [MAX_POINTS];

  logic            out_valid_r;
  logic [RW-1:0]   out_x_r, out_y_r, fin_x, fin_y;

  // whole back pipe moves together; it freezes only when the output is held
  assign adv   = !out_valid_r || out_tready;
  assign q_pop = adv && !q_empty;

  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      b_init[i] = q_cls.zero ? '0 : {binom(q_cls.deg, DEG_W'(i)), {T_FRAC_BITS{1'b0}}};
    end
  end

  // step s: lanes below index s+1 take a u factor, the others a t factor,
  // and only the first deg steps multiply at all
  always_comb begin
    logic [MW-1:0] m;
    logic [TW-1:0] f;
    for (int s = 0; s < NSTG; s++) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        f = (s < i) ? t_r[s] : u_r[s];
        m = MW'(b_r[s][i]) * MW'(f) + HALF_M;
        if (DEG_W'(s) < cls_r[s].deg) begin
          b_nxt[s][i] = m[T_FRAC_BITS +: WB];
        end else begin
          b_nxt[s][i] = b_r[s][i];
        end
      end
    end
  end

  function automatic logic [RW-1:0] finish(input logic [ACCW-1:0] acc);
    logic [FINW-1:0] r;
    r = ((FINW'(acc) << 8) + HALF_F) >> T_FRAC_BITS;
    return (r > OUT_MAX) ? OUT_MAX[RW-1:0] : r[RW-1:0];
  endfunction

  always_comb begin
    logic [ACCW-1:0] ax, ay;
    ax = '0;
    ay = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      ax = ax + ACCW'(px_r[i]);
      ay = ay + ACCW'(py_r[i]);
    end
    fin_x = finish(ax);
    fin_y = finish(ay);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NSTG; s++) begin
        vld_r[s] <= 1'b0;
      end
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= !q_empty;
      for (int s = 0; s < NSTG; s++) begin
        vld_r[s+1] <= vld_r[s];
      end
      prod_vld_r  <= vld_r[NSTG];
      out_valid_r <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_r[0] <= q_cls;
      for (int i = 0; i < MAX_POINTS; i++) begin
        b_r[0][i] <= b_init[i];
      end
      if (NSTG > 0) begin
        t_r[0] <= q_t;
        u_r[0] <= q_u;
      end
      for (int s = 0; s < NSTG; s++) begin
        cls_r[s+1] <= cls_r[s];
        for (int i = 0; i < MAX_POINTS; i++) begin
          b_r[s+1][i] <= b_nxt[s][i];
        end
        if (s + 1 < NSTG) begin
          t_r[s+1] <= t_r[s];
          u_r[s+1] <= u_r[s];
        end
      end
      for (int i = 0; i < MAX_POINTS; i++) begin
        px_r[i] <= PW'(b_r[NSTG][i]) * PW'(points[i][COORD_BITS-1:0]);
        py_r[i] <= PW'(b_r[NSTG][i]) * PW'(points[i][2*COORD_BITS-1:COORD_BITS]);
      end
      out_x_r <= fin_x;
      out_y_r <= fin_y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;

`ifndef SYNTHESIS
  a_top_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG] && (cls_r[NSTG].zero ||
                     cls_r[NSTG].deg < DEG_W'(MAX_POINTS - 1)))
      |-> (b_r[NSTG][MAX_POINTS-1] == '0))
    else $error("weight of unused control point is not zero");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> (!q_pop ##1 $stable(prod_vld_r)))
    else $error("back pipe moved while output held");
`endif

endmodule

`default_nettype wire
